FILE: rtl/sparse_matrix_multiply_core_defines.svh
// ----------------------------------------------------------------------------
// Sparse matrix multiply core assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define SPARSE_MATRIX_MULTIPLY_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sparse matrix multiply core: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sparse matrix multiply core: next-cycle check failed");

`endif

FILE: rtl/smm_pkg.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply package
// Widths, command codes and the cell control bundle shared by the core.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int DIM_DEF = 16;
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 36;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_WR_A  = 2'd1,
    FUNC_WR_B  = 2'd2,
    FUNC_ROW   = 2'd3
  } func_t;

  typedef struct packed {
    logic clr;
    logic acc_en;
    logic shift;
  } smm_cell_ctrl_t;

endpackage

FILE: rtl/smm_store.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply operand store
// Row-wide matrix memory with per-entry writes, a registered row read and
// per-entry valid bits so that unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module smm_store import smm_pkg::*; #(
  parameter int  DIM = DIM_DEF,
  localparam int AW  = $clog2(DIM)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    clr,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_row,
  input  logic [AW-1:0]           wr_col,
  input  logic [VAL_W-1:0]        wr_data,
  input  logic [AW-1:0]           rd_row,
  output logic [DIM*VAL_W-1:0]    rd_data
);

  logic [DIM*VAL_W-1:0] mem_r [DIM];
  logic [DIM-1:0]       vld_r [DIM];
  logic [DIM*VAL_W-1:0] rd_data_r;
  logic [DIM-1:0]       rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_row][wr_col*VAL_W +: VAL_W] <= wr_data;
    end
    rd_data_r <= mem_r[rd_row];
    rd_vld_r  <= vld_r[rd_row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i < DIM; i++) begin
        vld_r[i] <= '0;
      end
    end else if (wr_en) begin
      vld_r[wr_row][wr_col] <= 1'b1;
    end
  end

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      rd_data[j*VAL_W +: VAL_W] = rd_vld_r[j] ? rd_data_r[j*VAL_W +: VAL_W] : '0;
    end
  end

endmodule

FILE: rtl/smm_cell.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply column cell
// Holds the running sum of one product column: a registered multiply, an
// accumulate, and a shift toward the neighbor cell while results drain.
// ----------------------------------------------------------------------------
module smm_cell import smm_pkg::*; (
  input  logic                     clk,
  input  smm_cell_ctrl_t           ctrl,
  input  logic signed [VAL_W-1:0]  coef,
  input  logic signed [VAL_W-1:0]  rdat,
  input  logic signed [ACC_W-1:0]  shift_in,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     nz
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    prod_r <= coef * rdat;
    priority if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end else if (ctrl.shift) begin
      acc_r <= shift_in;
    end
  end

  assign acc = acc_r;
  assign nz  = (acc_r != '0);

endmodule

FILE: rtl/sparse_matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply core
// Stores two DIM x DIM matrices and returns the nonzero entries of one row
// of A*B (or B*A) per row request, in ascending column order.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid, in_stall  | in_func, in_row, in_col, in_value
//   out_    | output    | out_valid, out_stall| out_row, out_col, out_value,
//           |           |                     | out_has_value, out_last
//   cfg_    | input     | cfg_valid, cfg_ready| cfg_swap_operands
//
// A row request reads one row of the right operand store per cycle into a
// row of DIM cells, then drains one column per cycle through the cell chain
// while the output is not stalled.
// Reset is synchronous and clears both stores at once through valid bits.
// A stalled output holds its result while the drain waits for the slot.
// ----------------------------------------------------------------------------
`include "sparse_matrix_multiply_core_defines.svh"

module sparse_matrix_multiply_core import smm_pkg::*; #(
  parameter int  DIM = DIM_DEF,
  localparam int AW  = $clog2(DIM)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_func,
  input  logic [IDX_W-1:0]         in_row,
  input  logic [IDX_W-1:0]         in_col,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [ACC_W-1:0]  out_value,
  output logic                     out_has_value,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_swap_operands
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LREAD,
    S_RUN,
    S_FLUSH,
    S_EMIT
  } state_t;

  state_t                  state_r;
  logic [IDX_W-1:0]        row_r;
  logic [AW-1:0]           k_r;
  logic [AW-1:0]           kd_r;
  logic [AW-1:0]           col_r;
  logic                    iss_v_r;
  logic                    mul_v_r;
  logic                    swap_r;
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_row_r;
  logic [IDX_W-1:0]        out_col_r;
  logic signed [ACC_W-1:0] out_value_r;
  logic                    out_has_value_r;
  logic                    out_last_r;

  func_t                   func;
  logic                    in_acc;
  logic                    row_ok;
  logic                    col_ok;
  logic                    slot;
  logic                    nz_all;
  logic                    rest_nz;
  logic                    shift_en;
  smm_cell_ctrl_t          cell_ctrl;
  logic [AW-1:0]           rd_row_a;
  logic [AW-1:0]           rd_row_b;
  logic [DIM*VAL_W-1:0]    row_a;
  logic [DIM*VAL_W-1:0]    row_b;
  logic [DIM*VAL_W-1:0]    left_row;
  logic [DIM*VAL_W-1:0]    right_row;
  logic signed [VAL_W-1:0] coef;
  logic signed [ACC_W-1:0] acc [DIM];
  logic [DIM-1:0]          nz;

  assign func      = func_t'(in_func);
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign row_ok    = ({1'b0, in_row} < (IDX_W+1)'(DIM));
  assign col_ok    = ({1'b0, in_col} < (IDX_W+1)'(DIM));
  assign cfg_ready = 1'b1;

  assign rd_row_a  = swap_r ? k_r : row_r[AW-1:0];
  assign rd_row_b  = swap_r ? row_r[AW-1:0] : k_r;

  smm_store #(.DIM(DIM)) u_store_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (in_acc && func == FUNC_CLEAR),
    .wr_en   (in_acc && func == FUNC_WR_A && row_ok && col_ok),
    .wr_row  (in_row[AW-1:0]),
    .wr_col  (in_col[AW-1:0]),
    .wr_data (in_value),
    .rd_row  (rd_row_a),
    .rd_data (row_a)
  );

  smm_store #(.DIM(DIM)) u_store_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (in_acc && func == FUNC_CLEAR),
    .wr_en   (in_acc && func == FUNC_WR_B && row_ok && col_ok),
    .wr_row  (in_row[AW-1:0]),
    .wr_col  (in_col[AW-1:0]),
    .wr_data (in_value),
    .rd_row  (rd_row_b),
    .rd_data (row_b)
  );

  assign left_row  = swap_r ? row_b : row_a;
  assign right_row = swap_r ? row_a : row_b;
  assign coef      = left_row[kd_r*VAL_W +: VAL_W];

  assign slot     = !out_valid_r || !out_stall;
  assign nz_all   = |nz;
  assign rest_nz  = |nz[DIM-1:1];
  assign shift_en = (state_r == S_EMIT) && nz_all && (!nz[0] || (slot && rest_nz));

  assign cell_ctrl.clr    = in_acc && func == FUNC_ROW;
  assign cell_ctrl.acc_en = mul_v_r;
  assign cell_ctrl.shift  = shift_en;

  for (genvar j = 0; j < DIM; j++) begin : g_cell
    logic signed [ACC_W-1:0] shift_in;
    if (j == DIM - 1) begin : g_tail
      assign shift_in = '0;
    end else begin : g_link
      assign shift_in = acc[j+1];
    end
    smm_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .coef     (coef),
      .rdat     (right_row[j*VAL_W +: VAL_W]),
      .shift_in (shift_in),
      .acc      (acc[j]),
      .nz       (nz[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_v_r     <= 1'b0;
      mul_v_r     <= 1'b0;
      swap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        swap_r <= cfg_swap_operands;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      iss_v_r <= (state_r == S_RUN);
      kd_r    <= k_r;
      mul_v_r <= iss_v_r;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && func == FUNC_ROW) begin
            row_r   <= in_row;
            k_r     <= '0;
            col_r   <= '0;
            state_r <= row_ok ? S_LREAD : S_EMIT;
          end
        end
        S_LREAD: begin
          state_r <= S_RUN;
        end
        S_RUN: begin
          k_r <= k_r + 1'b1;
          if (k_r == AW'(DIM - 1)) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!iss_v_r && !mul_v_r) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          priority if (!nz_all) begin
            if (slot) begin
              out_valid_r     <= 1'b1;
              out_row_r       <= row_r;
              out_col_r       <= '0;
              out_value_r     <= '0;
              out_has_value_r <= 1'b0;
              out_last_r      <= 1'b1;
              state_r         <= S_IDLE;
            end
          end else if (!nz[0]) begin
            col_r <= col_r + 1'b1;
          end else if (slot) begin
            out_valid_r     <= 1'b1;
            out_row_r       <= row_r;
            out_col_r       <= IDX_W'(col_r);
            out_value_r     <= acc[0];
            out_has_value_r <= 1'b1;
            out_last_r      <= !rest_nz;
            if (rest_nz) begin
              col_r <= col_r + 1'b1;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_has_value = out_has_value_r;
  assign out_last      = out_last_r;

  // The multiply pipeline must be empty before results start to drain.
  `SMM_ASSERT_SAME(a_drain_after_flush, state_r == S_EMIT, !iss_v_r && !mul_v_r)
  // A row request moves the sequencer out of idle on the next cycle.
  `SMM_ASSERT_NEXT(a_row_starts, in_acc && func == FUNC_ROW,
                   state_r == S_LREAD || state_r == S_EMIT)
  // The empty-row result always closes its request.
  `SMM_ASSERT_SAME(a_empty_is_last, out_valid && !out_has_value, out_last)
  // The drained column never runs past the last cell.
  `SMM_ASSERT_SAME(a_col_in_range, state_r == S_EMIT, col_r <= AW'(DIM - 1))

endmodule

FILE: tb/sparse_matrix_multiply_core_test.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply core testbench
// Loads coordinate entries into both matrix stores, requests product rows in
// both operand orders, and checks every returned entry against a directed
// expectation or a behavioral product, under sender and receiver pacings.
// ----------------------------------------------------------------------------
module sparse_matrix_multiply_core_test;
  import smm_pkg::*;

  localparam int DIM         = DIM_DEF;
  localparam int TAIL_CYCLES = DIM + 12;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] value;
    logic                    has;
    logic                    last;
  } prod_entry_t;

  typedef struct {
    func_t                   func;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    bit                      typed;
    logic [IDX_W-1:0]        t_col;
    logic signed [ACC_W-1:0] t_value;
    logic                    t_has;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_func = 2'd0;
  logic [IDX_W-1:0]        in_row = '0;
  logic [IDX_W-1:0]        in_col = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [ACC_W-1:0] out_value;
  logic                    out_has_value;
  logic                    out_last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_swap_operands = 1'b0;

  logic signed [VAL_W-1:0] store_a [DIM*DIM];
  logic signed [VAL_W-1:0] store_b [DIM*DIM];
  logic                    swap_pred;
  prod_entry_t             pending_entries [$];
  stim_row_t               directed_table [$];

  int   mismatch_count = 0;
  int   entries_checked = 0;
  int   requests_sent = 0;
  int   rows_requested = 0;
  int   cycle_count = 0;
  int   send_pct = 0;
  int   recv_pct = 0;
  int   hold_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;

  sparse_matrix_multiply_core #(.DIM(DIM)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_value         (out_value),
    .out_has_value     (out_has_value),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_swap_operands (cfg_swap_operands)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d product entries outstanding", $time,
               pending_entries.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_toggle) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  function automatic void note_mismatch(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatch_count++;
  endfunction

  always @(posedge clk) begin
    prod_entry_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected product entry, expected none, got row %0d col %0d value %0d",
                 $time, out_row, out_col, out_value);
        mismatch_count++;
      end else begin
        want = pending_entries.pop_front();
        entries_checked++;
        if (out_row !== want.row)
          note_mismatch("out_row", longint'(want.row), longint'(out_row));
        if (out_col !== want.col)
          note_mismatch("out_col", longint'(want.col), longint'(out_col));
        if (out_value !== want.value)
          note_mismatch("out_value", longint'(want.value), longint'(out_value));
        if (out_has_value !== want.has)
          note_mismatch("out_has_value", longint'(want.has), longint'(out_has_value));
        if (out_last !== want.last)
          note_mismatch("out_last", longint'(want.last), longint'(out_last));
      end
    end
  end

  task automatic predict_product_row(input logic [IDX_W-1:0] r);
    longint                  acc [DIM];
    int                      last_col;
    prod_entry_t             e;
    logic signed [VAL_W-1:0] lv;
    logic signed [VAL_W-1:0] rv;
    last_col = -1;
    for (int j = 0; j < DIM; j++) begin
      acc[j] = 0;
      if (r < DIM) begin
        for (int k = 0; k < DIM; k++) begin
          lv = swap_pred ? store_b[r*DIM + k] : store_a[r*DIM + k];
          rv = swap_pred ? store_a[k*DIM + j] : store_b[k*DIM + j];
          acc[j] += longint'(lv) * longint'(rv);
        end
      end
      if (acc[j] != 0) last_col = j;
    end
    if (last_col < 0) begin
      e.row = r;
      e.col = '0;
      e.value = '0;
      e.has = 1'b0;
      e.last = 1'b1;
      pending_entries.push_back(e);
    end else begin
      for (int j = 0; j <= last_col; j++) begin
        if (acc[j] != 0) begin
          e.row = r;
          e.col = j[IDX_W-1:0];
          e.value = acc[j][ACC_W-1:0];
          e.has = 1'b1;
          e.last = (j == last_col);
          pending_entries.push_back(e);
        end
      end
    end
  endtask

  task automatic absorb_request(input func_t f, input logic [IDX_W-1:0] r,
                                input logic [IDX_W-1:0] c,
                                input logic signed [VAL_W-1:0] v, input bit predict);
    requests_sent++;
    case (f)
      FUNC_CLEAR: begin
        for (int i = 0; i < DIM*DIM; i++) begin
          store_a[i] = '0;
          store_b[i] = '0;
        end
      end
      FUNC_WR_A: begin
        if (r < DIM && c < DIM) store_a[r*DIM + c] = v;
      end
      FUNC_WR_B: begin
        if (r < DIM && c < DIM) store_b[r*DIM + c] = v;
      end
      default: begin
        rows_requested++;
        if (predict) predict_product_row(r);
      end
    endcase
  endtask

  // Called just after a rising edge; returns just after the accepting edge
  // or after the idle cycles that follow it.
  task automatic send_item(input func_t f, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c,
                           input logic signed [VAL_W-1:0] v, input bit predict);
    in_valid <= 1'b1;
    in_func <= f;
    in_row <= r;
    in_col <= c;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_request(f, r, c, v, predict);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    int                      pick;
    int                      tmp;
    func_t                   f;
    logic [IDX_W-1:0]        r;
    logic [IDX_W-1:0]        c;
    logic signed [VAL_W-1:0] v;
    tmp = $urandom_range(1) ? $urandom_range(3) : $urandom_range(15);
    r = tmp[IDX_W-1:0];
    tmp = $urandom_range(1) ? $urandom_range(3) : $urandom_range(15);
    c = tmp[IDX_W-1:0];
    case ($urandom_range(7))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = 16'sh0000;
      3: v = 16'shffff;
      default: begin
        tmp = $urandom;
        v = tmp[VAL_W-1:0];
      end
    endcase
    pick = $urandom_range(99);
    if (pick < 3) f = FUNC_CLEAR;
    else if (pick < 40) f = FUNC_WR_A;
    else if (pick < 75) f = FUNC_WR_B;
    else f = FUNC_ROW;
    send_item(f, r, c, v, 1'b1);
  endtask

  // Fills one row of the left operand and one column of the right operand
  // with full-scale values, then asks for that row.
  task automatic load_full_scale(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] j,
                                 input logic signed [VAL_W-1:0] right_val);
    func_t left_f;
    func_t right_f;
    left_f = swap_pred ? FUNC_WR_B : FUNC_WR_A;
    right_f = swap_pred ? FUNC_WR_A : FUNC_WR_B;
    for (int k = 0; k < DIM; k++) begin
      send_item(left_f, r, k[IDX_W-1:0], 16'sh8000, 1'b1);
      send_item(right_f, k[IDX_W-1:0], j, right_val, 1'b1);
    end
    send_item(FUNC_ROW, r, 4'd0, 16'sh0000, 1'b1);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_swap(input logic value);
    cfg_valid <= 1'b1;
    cfg_swap_operands <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    swap_pred = value;
  endtask

  task automatic set_pacing(input int sp, input int rp);
    send_pct = sp;
    recv_pct <= rp;
  endtask

  function automatic stim_row_t stim(input func_t f, input logic [IDX_W-1:0] r,
                                     input logic [IDX_W-1:0] c,
                                     input logic signed [VAL_W-1:0] v, input bit typed,
                                     input logic [IDX_W-1:0] t_col,
                                     input logic signed [ACC_W-1:0] t_value,
                                     input logic t_has);
    stim_row_t s;
    s.func = f;
    s.row = r;
    s.col = c;
    s.value = v;
    s.typed = typed;
    s.t_col = t_col;
    s.t_value = t_value;
    s.t_has = t_has;
    return s;
  endfunction

  initial begin
    prod_entry_t e;
    for (int i = 0; i < DIM*DIM; i++) begin
      store_a[i] = '0;
      store_b[i] = '0;
    end
    swap_pred = 1'b0;

    directed_table.push_back(stim(FUNC_ROW, 4'd0, 4'd0, 16'sh0000, 1'b1, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd15, 4'd15, 16'shffff, 1'b1, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_WR_A, 4'd0, 4'd0, 16'sh7fff, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd0, 4'd7, 16'sh1234, 1'b1, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_WR_B, 4'd0, 4'd0, 16'sh7fff, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd0, 4'd0, 16'sh0000, 1'b1, 4'd0,
                                  36'sd1073676289, 1'b1));
    directed_table.push_back(stim(FUNC_WR_A, 4'd15, 4'd15, 16'sh8000, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_WR_B, 4'd15, 4'd15, 16'sh8000, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd15, 4'd0, 16'sh0000, 1'b1, 4'd15,
                                  36'sd1073741824, 1'b1));
    directed_table.push_back(stim(FUNC_WR_A, 4'd0, 4'd15, 16'sh8000, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd0, 4'd0, 16'sh0000, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_WR_B, 4'd15, 4'd0, 16'sh7fff, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd0, 4'd0, 16'sh0000, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_WR_A, 4'd0, 4'd0, 16'sh0000, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd0, 4'd0, 16'sh0000, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_WR_A, 4'd0, 4'd15, 16'sh0000, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd0, 4'd0, 16'sh0000, 1'b1, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_WR_A, 4'd7, 4'd3, 16'shffff, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_WR_B, 4'd3, 4'd9, 16'sh0001, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd7, 4'd0, 16'sh0000, 1'b1, 4'd9,
                                  36'shf_ffff_ffff, 1'b1));
    directed_table.push_back(stim(FUNC_CLEAR, 4'd9, 4'd6, 16'sh5a5a, 1'b0, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd15, 4'd0, 16'sh0000, 1'b1, 4'd0, 36'sd0, 1'b0));
    directed_table.push_back(stim(FUNC_ROW, 4'd7, 4'd0, 16'sh0000, 1'b1, 4'd0, 36'sd0, 1'b0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_pacing(0, 0);
    foreach (directed_table[i]) begin
      if (directed_table[i].typed) begin
        e.row = directed_table[i].row;
        e.col = directed_table[i].t_col;
        e.value = directed_table[i].t_value;
        e.has = directed_table[i].t_has;
        e.last = 1'b1;
        pending_entries.push_back(e);
      end
      send_item(directed_table[i].func, directed_table[i].row, directed_table[i].col,
                directed_table[i].value, !directed_table[i].typed);
    end
    wait_drain();

    write_swap(1'b1);
    set_pacing(54, 0);
    repeat (30) send_random_item();
    wait_drain();

    write_swap(1'b0);
    set_pacing(0, 54);
    repeat (30) send_random_item();
    wait_drain();

    write_swap(1'b1);
    set_pacing(22, 22);
    repeat (30) send_random_item();
    wait_drain();

    // The output is held off while row requests keep arriving back to back.
    write_swap(1'b0);
    set_pacing(0, 0);
    load_full_scale(4'd2, 4'd5, 16'sh8000);
    hold_toggle <= ~hold_toggle;
    for (int i = 0; i < 14; i++) send_item(FUNC_ROW, i[IDX_W-1:0], 4'd0, 16'sh0000, 1'b1);
    repeat (10) send_random_item();
    wait_drain();

    write_swap(1'b1);
    set_pacing(22, 22);
    load_full_scale(4'd11, 4'd14, 16'sh7fff);
    repeat (10) send_random_item();
    wait_drain();

    $display("run: %0d requests, %0d row reads, %0d product entries checked", requests_sent,
             rows_requested, entries_checked);
    $display("run: both operand orders, four pacings, a long output hold, full-scale sums");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
